>>> rtl/mbsp_pkg.sv
`default_nettype none

package mbsp_pkg;

  // Byte codes on the link
  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;

  // Upper nibbles of the one-data-byte channel messages
  localparam logic [3:0] TYPE_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] TYPE_CHAN_PRESS   = 4'hD;

  // SysEx length limit and counter
  localparam int unsigned   COUNT_W     = 13;
  localparam logic [12:0]   LIMIT_RESET = 13'd4096;
  localparam logic [12:0]   COUNT_MAX   = 13'h1FFF;

  typedef enum logic [1:0] {
    KIND_CHANNEL   = 2'd0,
    KIND_SYSEX     = 2'd1,
    KIND_SYSEX_END = 2'd2,
    KIND_ABORT     = 2'd3
  } kind_t;

  // Parser state carried from item to item
  typedef struct packed {
    logic               in_sysex;
    logic [COUNT_W-1:0] sysex_count;
    logic [7:0]         running_status;
    logic [6:0]         held_data;
    logic               held_count;
    logic               needs_two;
  } state_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [7:0] sysex_data;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/midi_byte_stream_parser.sv
// Channel  | Direction | Handshake             | Payload
// input    | in        | in_valid / in_stall   | rx_byte
// result   | out       | out_valid / out_stall | result_kind, status_byte, first_data,
//          |           |                       | second_data, sysex_data
// config   | in        | cfg_write             | cfg_data (sysex_length_limit)
//
// One item per cycle sustained unless the result side stalls; an accepted byte sits
// in the input register; any result then moves to the result register, on the outputs.
// Reset (rst, synchronous) empties both stages, clears the parser state and sets the
// SysEx length limit to 4096.
// A stall on the result side holds both stages and is passed straight back as in_stall.
`default_nettype none

module midi_byte_stream_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           result_kind,
  output logic [7:0]                           status_byte,
  output logic [6:0]                           first_data,
  output logic [6:0]                           second_data,
  output logic [7:0]                           sysex_data,
  input  wire logic                            cfg_write,
  input  wire logic [mbsp_pkg::COUNT_W-1:0]    cfg_data
);

  logic                            advance;
  logic                            s1_valid;
  logic [7:0]                      s1_byte;
  logic [mbsp_pkg::COUNT_W-1:0]    limit;
  mbsp_pkg::state_t                st;
  mbsp_pkg::state_t                st_next;
  logic                            emit;
  mbsp_pkg::result_t               res;
  mbsp_pkg::result_t               out_res;

  // pipeline moves unless a result is waiting to be taken
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  mbsp_decode u_decode (
    .st      (st),
    .rx      (s1_byte),
    .limit   (limit),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  // control: stage valids, parser state, limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
      limit     <= mbsp_pkg::LIMIT_RESET;
    end else begin
      if (cfg_write) begin
        limit <= cfg_data;
      end
      if (advance) begin
        s1_valid  <= in_valid;
        out_valid <= s1_valid && emit;
        if (s1_valid) begin
          st <= st_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_byte <= rx_byte;
      if (s1_valid && emit) begin
        out_res <= res;
      end
    end
  end

  assign result_kind = out_res.kind;
  assign status_byte = out_res.status_byte;
  assign first_data  = out_res.first_data;
  assign second_data = out_res.second_data;
  assign sysex_data  = out_res.sysex_data;

endmodule

`default_nettype wire

>>> rtl/mbsp_decode.sv
`default_nettype none

// Decision logic for one received byte: next parser state and the result, if any.
module mbsp_decode (
  input  wire mbsp_pkg::state_t             st,
  input  wire logic [7:0]                   rx,
  input  wire logic [mbsp_pkg::COUNT_W-1:0] limit,
  output mbsp_pkg::state_t                  st_next,
  output logic                              emit,
  output mbsp_pkg::result_t                 res
);

  always_comb begin
    st_next         = st;
    emit            = 1'b0;
    res             = '0;
    res.kind        = mbsp_pkg::KIND_CHANNEL;

    priority if (rx >= mbsp_pkg::REALTIME_MIN) begin
      // realtime: dropped, state untouched
    end else if (rx == mbsp_pkg::SYSEX_START) begin
      // start (or restart) of SysEx, F0 counted
      st_next.in_sysex    = 1'b1;
      st_next.sysex_count = mbsp_pkg::COUNT_W'(1);
      emit                = 1'b1;
      res.kind            = mbsp_pkg::KIND_SYSEX;
      res.sysex_data      = rx;
    end else if (st.in_sysex) begin
      if (rx == mbsp_pkg::SYSEX_END) begin
        // F7 always closes normally; count saturates
        st_next.in_sysex = 1'b0;
        if (st.sysex_count < mbsp_pkg::COUNT_MAX) begin
          st_next.sysex_count = st.sysex_count + mbsp_pkg::COUNT_W'(1);
        end
        emit           = 1'b1;
        res.kind       = mbsp_pkg::KIND_SYSEX_END;
        res.sysex_data = rx;
      end else if (st.sysex_count >= limit) begin
        // too long: abandon the message
        st_next.in_sysex = 1'b0;
        emit             = 1'b1;
        res.kind         = mbsp_pkg::KIND_ABORT;
      end else begin
        st_next.sysex_count = st.sysex_count + mbsp_pkg::COUNT_W'(1);
        emit                = 1'b1;
        res.kind            = mbsp_pkg::KIND_SYSEX;
        res.sysex_data      = rx;
      end
    end else if (rx[7]) begin
      // new running status
      st_next.running_status = rx;
      st_next.held_count     = 1'b0;
      st_next.needs_two      = !((rx[7:4] == mbsp_pkg::TYPE_PROG_CHANGE) ||
                                 (rx[7:4] == mbsp_pkg::TYPE_CHAN_PRESS));
    end else if (st.running_status == 8'h00) begin
      // data with no status: dropped
    end else if (!st.held_count) begin
      if (!st.needs_two) begin
        emit            = 1'b1;
        res.status_byte = st.running_status;
        res.first_data  = rx[6:0];
      end else begin
        st_next.held_data  = rx[6:0];
        st_next.held_count = 1'b1;
      end
    end else begin
      // second data byte completes the message
      st_next.held_count = 1'b0;
      emit               = 1'b1;
      res.status_byte    = st.running_status;
      res.first_data     = st.held_data;
      res.second_data    = rx[6:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/mbsp_checker.sv
`default_nettype none

module mbsp_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [1:0] result_kind,
  input  wire logic [7:0] status_byte,
  input  wire logic [6:0] first_data,
  input  wire logic [6:0] second_data,
  input  wire logic [7:0] sysex_data
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(sysex_data)
      && $stable(status_byte) && $stable(first_data) && $stable(second_data))
    else $error("result item changed under stall");

  // channel messages carry a status byte and no SysEx data
  a_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == mbsp_pkg::KIND_CHANNEL |-> status_byte[7] && sysex_data == 8'h00)
    else $error("malformed channel message");

  // SysEx kinds leave the channel fields clear
  a_sysex_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != mbsp_pkg::KIND_CHANNEL
      |-> status_byte == 8'h00 && first_data == 7'h00 && second_data == 7'h00)
    else $error("channel fields set on SysEx item");

  // the closing item carries F7, an abort carries nothing
  a_sysex_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == mbsp_pkg::KIND_SYSEX_END || result_kind == mbsp_pkg::KIND_ABORT)
      |-> (result_kind == mbsp_pkg::KIND_SYSEX_END && sysex_data == mbsp_pkg::SYSEX_END)
       || (result_kind == mbsp_pkg::KIND_ABORT && sysex_data == 8'h00))
    else $error("bad SysEx end or abort item");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .status_byte (status_byte),
  .first_data  (first_data),
  .second_data (second_data),
  .sysex_data  (sysex_data)
);

`default_nettype wire
